[rtl/nnis_pkg.sv]
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared codes and widths of the nearest-neighbour image scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnis_pkg;

	localparam int PixW   = 32;
	localparam int IndexW = 16;
	localparam int DimW   = 9;
	localparam int ChanW  = 3;
	localparam int ScaleW = 16;
	localparam int HdrW   = 16;
	localparam int FileW  = 36;
	localparam int PadW   = 2;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	// fraction bits of the scale, and quotient width of the index division
	localparam int FracW = 8;
	localparam int DivW  = IndexW + FracW;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	localparam logic [CfgIdxW-1:0] CFG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_CHANNELS      = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_SCALE_Q8      = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_HEADER_BYTES  = 3'd4;

endpackage

`default_nettype wire

[rtl/nnis_item_if.sv]
// ----------------------------------------------------------------------------
// nnis_item_if
// Input channel of the scaler: load and fetch items.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnis_item_if
	import nnis_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              func;
	logic [IndexW-1:0] row_index;
	logic [IndexW-1:0] col_index;
	logic [PixW-1:0]   pixel_in;

	modport source (output valid, func, row_index, col_index, pixel_in, input ready);
	modport sink   (input valid, func, row_index, col_index, pixel_in, output ready);
endinterface

`default_nettype wire

[rtl/nnis_result_if.sv]
// ----------------------------------------------------------------------------
// nnis_result_if
// Output channel of the scaler: one result per fetch.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnis_result_if
	import nnis_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [PixW-1:0]   pixel_out;
	logic              out_of_range;
	logic [IndexW-1:0] scaled_width;
	logic [IndexW-1:0] scaled_height;
	logic [PadW-1:0]   row_padding;
	logic [FileW-1:0]  file_bytes;

	modport source (output valid, pixel_out, out_of_range, scaled_width, scaled_height,
		row_padding, file_bytes, input ready);
	modport sink   (input valid, pixel_out, out_of_range, scaled_width, scaled_height,
		row_padding, file_bytes, output ready);
endinterface

`default_nettype wire

[rtl/nnis_ram.sv]
// ----------------------------------------------------------------------------
// nnis_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/nearest_neighbor_image_scaler_core.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_core
// Nearest-neighbour image scaler over a pixel store in block RAM.
// ----------------------------------------------------------------------------
// A load item writes one packed pixel into the source store when its row and
// column lie inside the clamped source size, and gives no result. A fetch item
// divides the output row and column by the Q8.8 scale in two restoring dividers
// running side by side, one quotient bit per cycle, then reads the store in the
// read step and hands the result to the output register in the finish step;
// the next item is taken once the fetch is back in idle, so a fetch holds the
// input for its whole run. A fetch also waits in its last step while the
// previous result has not been taken. Sizes, padding and file size come from a
// short pipeline fed by the configuration registers and are settled long
// before the fetch finishes. The store is not cleared at reset; reading a
// pixel never loaded gives an undefined value.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_image_scaler_core
	import nnis_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [CfgIdxW-1:0]  reg_index,
	input  wire logic [CfgDataW-1:0] wr_data,
	nnis_item_if.sink                item,
	nnis_result_if.source            result
);

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(DivW);
	localparam int LimW  = 13;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_FIN
	} state_t;

	// configuration
	logic [DimW-1:0]   src_width_q;
	logic [DimW-1:0]   src_height_q;
	logic [ChanW-1:0]  channels_q;
	logic [ScaleW-1:0] scale_q;
	logic [HdrW-1:0]   header_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DimW'(1);
			src_height_q <= DimW'(1);
			channels_q   <= ChanW'(4);
			scale_q      <= ScaleW'(256);
			header_q     <= HdrW'(54);
		end else if (wr_en) begin
			unique case (reg_index)
				CFG_SOURCE_WIDTH:  src_width_q  <= wr_data[DimW-1:0];
				CFG_SOURCE_HEIGHT: src_height_q <= wr_data[DimW-1:0];
				CFG_CHANNELS:      channels_q   <= wr_data[ChanW-1:0];
				CFG_SCALE_Q8:      scale_q      <= wr_data[ScaleW-1:0];
				CFG_HEADER_BYTES:  header_q     <= wr_data[HdrW-1:0];
				default: ;
			endcase
		end
	end

	// clamp to the store size
	logic [DimW-1:0] w_eff;
	logic [DimW-1:0] h_eff;

	assign w_eff = ({{(LimW-DimW){1'b0}}, src_width_q} > LimW'(MAX_WIDTH))
		? DimW'(MAX_WIDTH) : src_width_q;
	assign h_eff = ({{(LimW-DimW){1'b0}}, src_height_q} > LimW'(MAX_HEIGHT))
		? DimW'(MAX_HEIGHT) : src_height_q;

	// size pipeline, free running from the configuration
	logic [DimW+ScaleW-1:0] prod_w_s1, prod_h_s1;
	logic [IndexW-1:0]      nw_s2, nh_s2, nw_s3, nh_s3, nw_s4, nh_s4;
	logic [2*IndexW-1:0]    area_s3;
	logic [PadW-1:0]        pad_s3, pad_s4;
	logic [FileW-1:0]       bytes_s4;
	logic [PadW-1:0]        pad_mod;

	assign pad_mod = PadW'(nw_s2[PadW-1:0] * channels_q[PadW-1:0]);

	always_ff @(posedge clk) begin
		prod_w_s1 <= (DimW+ScaleW)'(w_eff) * (DimW+ScaleW)'(scale_q);
		prod_h_s1 <= (DimW+ScaleW)'(h_eff) * (DimW+ScaleW)'(scale_q);
		nw_s2     <= prod_w_s1[DimW+ScaleW-1] ? '1 : prod_w_s1[DimW+ScaleW-2:FracW];
		nh_s2     <= prod_h_s1[DimW+ScaleW-1] ? '1 : prod_h_s1[DimW+ScaleW-2:FracW];
		area_s3   <= (2*IndexW)'(nw_s2) * (2*IndexW)'(nh_s2);
		pad_s3    <= PadW'(2'd0 - pad_mod);
		nw_s3     <= nw_s2;
		nh_s3     <= nh_s2;
		bytes_s4  <= FileW'(header_q) + FileW'(area_s3) * FileW'(channels_q)
			+ FileW'(nh_s3) * FileW'(pad_s3);
		pad_s4    <= pad_s3;
		nw_s4     <= nw_s3;
		nh_s4     <= nh_s3;
	end

	function automatic logic [AddrW-1:0] pix_addr(input logic [DivW-1:0] r,
		input logic [DivW-1:0] c);
		return AddrW'(AddrW'(r) * AddrW'(MAX_WIDTH) + AddrW'(c));
	endfunction

	// store
	logic             ram_we;
	logic [AddrW-1:0] ram_waddr;
	logic             ram_re;
	logic [AddrW-1:0] ram_raddr;
	logic [PixW-1:0]  ram_rdata;

	state_t            state_q;
	logic [CntW-1:0]   cnt_q;
	logic [IndexW-1:0] row_q, col_q;
	logic [DivW-1:0]   dq_r_q, dq_c_q;
	logic [ScaleW-1:0] rem_r_q, rem_c_q;
	logic              out_valid_q;
	logic [PixW-1:0]   pix_out_q;
	logic              oor_q;
	logic [IndexW-1:0] sw_out_q, sh_out_q;
	logic [PadW-1:0]   pad_out_q;
	logic [FileW-1:0]  bytes_out_q;

	logic item_xfer, result_xfer;

	assign item.ready  = (state_q == S_IDLE);
	assign item_xfer   = item.valid && item.ready;
	assign result_xfer = out_valid_q && result.ready;

	assign ram_we    = item_xfer && (item.func == FUNC_LOAD)
		&& (item.row_index < IndexW'(h_eff)) && (item.col_index < IndexW'(w_eff));
	assign ram_waddr = pix_addr(DivW'(item.row_index), DivW'(item.col_index));
	assign ram_re    = (state_q == S_RD);
	assign ram_raddr = pix_addr(dq_r_q, dq_c_q);

	nnis_ram #(
		.WIDTH (PixW),
		.DEPTH (Depth)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item.pixel_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// restoring division steps
	logic [ScaleW:0]   trial_r, trial_c;
	logic              take_r, take_c;
	logic [ScaleW:0]   diff_r, diff_c;

	assign trial_r = {rem_r_q, dq_r_q[DivW-1]};
	assign trial_c = {rem_c_q, dq_c_q[DivW-1]};
	assign diff_r  = trial_r - {1'b0, scale_q};
	assign diff_c  = trial_c - {1'b0, scale_q};
	assign take_r  = (trial_r >= {1'b0, scale_q});
	assign take_c  = (trial_c >= {1'b0, scale_q});

	// result selection
	logic            hit;
	logic [PixW-1:0] masked;

	assign hit = (row_q < nh_s4) && (col_q < nw_s4)
		&& (dq_r_q < DivW'(h_eff)) && (dq_c_q < DivW'(w_eff));

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			masked[8*i +: 8] = (ChanW'(i) < channels_q) ? ram_rdata[8*i +: 8] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			dq_r_q      <= '0;
			dq_c_q      <= '0;
			rem_r_q     <= '0;
			rem_c_q     <= '0;
			pix_out_q   <= '0;
			oor_q       <= 1'b0;
			sw_out_q    <= '0;
			sh_out_q    <= '0;
			pad_out_q   <= '0;
			bytes_out_q <= '0;
		end else begin
			// in the finish step a taken result is replaced by the new one
			if (result_xfer && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_xfer && (item.func == FUNC_FETCH)) begin
						row_q   <= item.row_index;
						col_q   <= item.col_index;
						dq_r_q  <= {item.row_index, {FracW{1'b0}}};
						dq_c_q  <= {item.col_index, {FracW{1'b0}}};
						rem_r_q <= '0;
						rem_c_q <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_r_q <= take_r ? diff_r[ScaleW-1:0] : trial_r[ScaleW-1:0];
					rem_c_q <= take_c ? diff_c[ScaleW-1:0] : trial_c[ScaleW-1:0];
					dq_r_q  <= {dq_r_q[DivW-2:0], take_r};
					dq_c_q  <= {dq_c_q[DivW-2:0], take_c};
					cnt_q   <= cnt_q + CntW'(1);
					if (cnt_q == CntW'(DivW - 1)) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						pix_out_q   <= hit ? masked : '0;
						oor_q       <= !hit;
						sw_out_q    <= nw_s4;
						sh_out_q    <= nh_s4;
						pad_out_q   <= pad_s4;
						bytes_out_q <= bytes_s4;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.pixel_out     = pix_out_q;
	assign result.out_of_range  = oor_q;
	assign result.scaled_width  = sw_out_q;
	assign result.scaled_height = sh_out_q;
	assign result.row_padding   = pad_out_q;
	assign result.file_bytes    = bytes_out_q;

	// checks
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && oor_q |-> pix_out_q == '0)
		else $error("out-of-range result carries a pixel");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q < CntW'(DivW))
		else $error("divider step count overrun");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_IDLE && !ram_re)
		else $error("store written during a fetch");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside the finish step");

	a_read_before_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |=> state_q == S_FIN)
		else $error("store read not followed by finish step");

endmodule

`default_nettype wire
